// ===== sv/nkro_pkg.sv =====
package nkro_pkg;

  localparam logic [3:0] FUNC_PRESS         = 4'd0;
  localparam logic [3:0] FUNC_RELEASE       = 4'd1;
  localparam logic [3:0] FUNC_TYPE          = 4'd2;
  localparam logic [3:0] FUNC_MEDIA_PRESS   = 4'd3;
  localparam logic [3:0] FUNC_MEDIA_RELEASE = 4'd4;
  localparam logic [3:0] FUNC_MEDIA_TYPE    = 4'd5;
  localparam logic [3:0] FUNC_RELEASE_ALL   = 4'd6;
  localparam logic [3:0] FUNC_LINK_UP       = 4'd7;
  localparam logic [3:0] FUNC_LINK_DOWN     = 4'd8;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_KEYBOARD = 2'd1;
  localparam logic [1:0] KIND_MEDIA    = 2'd2;

  localparam logic [7:0] USAGE_BASE = 8'h88;
  localparam logic [7:0] MOD_BASE   = 8'h80;
  localparam logic [7:0] LSHIFT     = 8'h02;

  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  key_code;
    logic [15:0] media_mask;
  } ev_t;

  typedef struct packed {
    logic [7:0] report_byte;
    logic [1:0] report_kind;
    logic       status;
    logic       last;
  } rpt_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_KEY_SET,
    OP_KEY_CLR,
    OP_MEDIA_SET,
    OP_MEDIA_CLR,
    OP_CLEAR_ALL,
    OP_LINK_UP,
    OP_LINK_DOWN
  } op_e;

  typedef struct packed {
    logic       en;
    op_e        op;
    logic [7:0] mod_mask;
    logic       bit_en;
    logic [6:0] idx;
    logic       send;
    logic       ok;
  } phase_t;

  typedef struct packed {
    phase_t [1:0] ph;
    logic [15:0]  mask;
    logic         ok;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_EMIT,
    ST_STATUS
  } st_e;

  // ASCII to HID usage; bit 7 marks a shifted character
  function automatic logic [7:0] ascii_map(input logic [6:0] c);
    logic [7:0] m;
    case (c)
      7'h08: m = 8'h2a; 7'h09: m = 8'h2b; 7'h0a: m = 8'h28;
      7'h20: m = 8'h2c; 7'h21: m = 8'h9e; 7'h22: m = 8'hb4; 7'h23: m = 8'ha0;
      7'h24: m = 8'ha1; 7'h25: m = 8'ha2; 7'h26: m = 8'ha4; 7'h27: m = 8'h34;
      7'h28: m = 8'ha6; 7'h29: m = 8'ha7; 7'h2a: m = 8'ha5; 7'h2b: m = 8'hae;
      7'h2c: m = 8'h36; 7'h2d: m = 8'h2d; 7'h2e: m = 8'h37; 7'h2f: m = 8'h38;
      7'h30: m = 8'h27; 7'h31: m = 8'h1e; 7'h32: m = 8'h1f; 7'h33: m = 8'h20;
      7'h34: m = 8'h21; 7'h35: m = 8'h22; 7'h36: m = 8'h23; 7'h37: m = 8'h24;
      7'h38: m = 8'h25; 7'h39: m = 8'h26; 7'h3a: m = 8'hb3; 7'h3b: m = 8'h33;
      7'h3c: m = 8'hb6; 7'h3d: m = 8'h2e; 7'h3e: m = 8'hb7; 7'h3f: m = 8'hb8;
      7'h40: m = 8'h9f; 7'h41: m = 8'h84; 7'h42: m = 8'h85; 7'h43: m = 8'h86;
      7'h44: m = 8'h87; 7'h45: m = 8'h88; 7'h46: m = 8'h89; 7'h47: m = 8'h8a;
      7'h48: m = 8'h8b; 7'h49: m = 8'h8c; 7'h4a: m = 8'h8d; 7'h4b: m = 8'h8e;
      7'h4c: m = 8'h8f; 7'h4d: m = 8'h90; 7'h4e: m = 8'h91; 7'h4f: m = 8'h92;
      7'h50: m = 8'h93; 7'h51: m = 8'h94; 7'h52: m = 8'h95; 7'h53: m = 8'h96;
      7'h54: m = 8'h97; 7'h55: m = 8'h98; 7'h56: m = 8'h99; 7'h57: m = 8'h9a;
      7'h58: m = 8'h9b; 7'h59: m = 8'h9c; 7'h5a: m = 8'h9d; 7'h5b: m = 8'h2f;
      7'h5c: m = 8'h31; 7'h5d: m = 8'h30; 7'h5e: m = 8'ha3; 7'h5f: m = 8'had;
      7'h60: m = 8'h35; 7'h61: m = 8'h04; 7'h62: m = 8'h05; 7'h63: m = 8'h06;
      7'h64: m = 8'h07; 7'h65: m = 8'h08; 7'h66: m = 8'h09; 7'h67: m = 8'h0a;
      7'h68: m = 8'h0b; 7'h69: m = 8'h0c; 7'h6a: m = 8'h0d; 7'h6b: m = 8'h0e;
      7'h6c: m = 8'h0f; 7'h6d: m = 8'h10; 7'h6e: m = 8'h11; 7'h6f: m = 8'h12;
      7'h70: m = 8'h13; 7'h71: m = 8'h14; 7'h72: m = 8'h15; 7'h73: m = 8'h16;
      7'h74: m = 8'h17; 7'h75: m = 8'h18; 7'h76: m = 8'h19; 7'h77: m = 8'h1a;
      7'h78: m = 8'h1b; 7'h79: m = 8'h1c; 7'h7a: m = 8'h1d; 7'h7b: m = 8'haf;
      7'h7c: m = 8'hb1; 7'h7d: m = 8'hb0; 7'h7e: m = 8'hb5;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/nkro_front.sv =====
module nkro_front #(
  parameter int KEY_BYTES = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  nkro_pkg::ev_t    ev_i,
  output logic             cmd_vld_o,
  input  logic             cmd_rdy_i,
  output nkro_pkg::cmd_t   cmd_o
);

  function automatic logic usage_ok(input logic [6:0] k);
    return (k != 7'd0) && ((int'(k) >> 3) < KEY_BYTES);
  endfunction

  function automatic nkro_pkg::phase_t dec_key(input logic [7:0] code, input logic rel);
    nkro_pkg::phase_t p;
    logic [7:0]       m;
    logic [6:0]       k;
    p      = '0;
    p.en   = 1'b1;
    p.op   = rel ? nkro_pkg::OP_KEY_CLR : nkro_pkg::OP_KEY_SET;
    m      = nkro_pkg::ascii_map(code[6:0]);
    k      = 7'(code - nkro_pkg::USAGE_BASE);
    if (code >= nkro_pkg::USAGE_BASE) begin
      p.idx    = k;
      p.bit_en = usage_ok(k);
      p.send   = rel | usage_ok(k);
      p.ok     = rel | usage_ok(k);
    end else if (code >= nkro_pkg::MOD_BASE) begin
      p.mod_mask = 8'd1 << code[2:0];
      p.send     = 1'b1;
      p.ok       = 1'b1;
    end else if (m != 8'd0) begin
      // shifted character takes left shift along even if the usage fails
      p.mod_mask = m[7] ? nkro_pkg::LSHIFT : 8'd0;
      p.idx      = m[6:0];
      p.bit_en   = usage_ok(m[6:0]);
      p.send     = rel | usage_ok(m[6:0]);
      p.ok       = rel | usage_ok(m[6:0]);
    end
    return p;
  endfunction

  function automatic nkro_pkg::phase_t dec_op(input nkro_pkg::op_e op, input logic send);
    nkro_pkg::phase_t p;
    p      = '0;
    p.en   = 1'b1;
    p.op   = op;
    p.send = send;
    p.ok   = 1'b1;
    return p;
  endfunction

  nkro_pkg::cmd_t dec;

  always_comb begin
    dec      = '0;
    dec.mask = ev_i.media_mask;
    dec.ok   = 1'b1;
    case (ev_i.func)
      nkro_pkg::FUNC_PRESS: begin
        dec.ph[0] = dec_key(ev_i.key_code, 1'b0);
        dec.ok    = dec.ph[0].ok;
      end
      nkro_pkg::FUNC_RELEASE: begin
        dec.ph[0] = dec_key(ev_i.key_code, 1'b1);
        dec.ok    = dec.ph[0].ok;
      end
      nkro_pkg::FUNC_TYPE: begin
        dec.ph[0] = dec_key(ev_i.key_code, 1'b0);
        dec.ph[1] = dec_key(ev_i.key_code, 1'b1);
        dec.ok    = dec.ph[0].ok;
      end
      nkro_pkg::FUNC_MEDIA_PRESS:   dec.ph[0] = dec_op(nkro_pkg::OP_MEDIA_SET, 1'b1);
      nkro_pkg::FUNC_MEDIA_RELEASE: dec.ph[0] = dec_op(nkro_pkg::OP_MEDIA_CLR, 1'b1);
      nkro_pkg::FUNC_MEDIA_TYPE: begin
        dec.ph[0] = dec_op(nkro_pkg::OP_MEDIA_SET, 1'b1);
        dec.ph[1] = dec_op(nkro_pkg::OP_MEDIA_CLR, 1'b1);
      end
      nkro_pkg::FUNC_RELEASE_ALL: dec.ph[0] = dec_op(nkro_pkg::OP_CLEAR_ALL, 1'b1);
      nkro_pkg::FUNC_LINK_UP:     dec.ph[0] = dec_op(nkro_pkg::OP_LINK_UP, 1'b0);
      nkro_pkg::FUNC_LINK_DOWN:   dec.ph[0] = dec_op(nkro_pkg::OP_LINK_DOWN, 1'b0);
      default: ;
    endcase
  end

  // two-entry command queue
  nkro_pkg::cmd_t q_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o    = (cnt_q == 2'd2);
  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = q_q[rd_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = cmd_vld_o && cmd_rdy_i;

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[wr_q] <= dec;
    end
  end

endmodule

// ===== sv/nkro_back.sv =====
module nkro_back #(
  parameter int KEY_BYTES = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_vld_i,
  output logic             cmd_rdy_o,
  input  nkro_pkg::cmd_t   cmd_i,
  output logic             out_vld_o,
  input  logic             pop_i,
  output nkro_pkg::rpt_t   rpt_o
);

  localparam int BMP_W  = KEY_BYTES * 8;
  localparam int BIT_W  = $clog2(BMP_W);
  localparam int BYTE_W = $clog2(KEY_BYTES);
  localparam int CNT_W  = $clog2(KEY_BYTES + 2);

  nkro_pkg::st_e    st_q, st_d;
  nkro_pkg::cmd_t   cmd_q, cmd_d;
  nkro_pkg::rpt_t   out_q, out_d;
  nkro_pkg::phase_t cur;
  logic             ph_q, ph_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       kind_q, kind_d;
  logic             more_q, more_d;
  logic             emitted_q, emitted_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       mod_q, mod_d;
  logic [BMP_W-1:0] bmp_q, bmp_d;
  logic [15:0]      media_q, media_d;
  logic             link_q, link_d;

  logic              slot_free, emit_now, at_end, is_media;
  logic [BYTE_W-1:0] bidx;
  logic [7:0]        sel_byte;

  assign cur       = cmd_q.ph[ph_q];
  assign slot_free = !out_vld_q || pop_i;
  assign emit_now  = cur.en && cur.send && link_q;
  assign is_media  = (cur.op == nkro_pkg::OP_MEDIA_SET) || (cur.op == nkro_pkg::OP_MEDIA_CLR);
  assign at_end    = (kind_q == nkro_pkg::KIND_KEYBOARD) ? (cnt_q == CNT_W'(KEY_BYTES + 1))
                                                         : (cnt_q == CNT_W'(1));
  assign bidx      = BYTE_W'(cnt_q - CNT_W'(2));
  assign out_vld_o = out_vld_q;
  assign rpt_o     = out_q;

  always_comb begin
    if (kind_q == nkro_pkg::KIND_MEDIA) begin
      sel_byte = (cnt_q == CNT_W'(0)) ? media_q[15:8] : media_q[7:0];
    end else if (cnt_q == CNT_W'(0)) begin
      sel_byte = mod_q;
    end else if (cnt_q == CNT_W'(1)) begin
      sel_byte = 8'd0;
    end else begin
      sel_byte = bmp_q[{bidx, 3'b000} +: 8];
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      nkro_pkg::ST_IDLE:   if (cmd_vld_i) st_d = nkro_pkg::ST_APPLY;
      nkro_pkg::ST_APPLY: begin
        if (emit_now)       st_d = nkro_pkg::ST_EMIT;
        else if (ph_q)      st_d = emitted_q ? nkro_pkg::ST_IDLE : nkro_pkg::ST_STATUS;
      end
      nkro_pkg::ST_EMIT: begin
        if (slot_free && at_end) st_d = ph_q ? nkro_pkg::ST_IDLE : nkro_pkg::ST_APPLY;
      end
      nkro_pkg::ST_STATUS: if (slot_free) st_d = nkro_pkg::ST_IDLE;
      default: st_d = nkro_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d     = cmd_q;
    out_d     = out_q;
    ph_d      = ph_q;
    cnt_d     = cnt_q;
    kind_d    = kind_q;
    more_d    = more_q;
    emitted_d = emitted_q;
    mod_d     = mod_q;
    bmp_d     = bmp_q;
    media_d   = media_q;
    link_d    = link_q;
    cmd_rdy_o = 1'b0;
    out_vld_d = out_vld_q && !pop_i;
    case (st_q)
      nkro_pkg::ST_IDLE: begin
        cmd_rdy_o = 1'b1;
        if (cmd_vld_i) begin
          cmd_d     = cmd_i;
          ph_d      = 1'b0;
          emitted_d = 1'b0;
        end
      end
      nkro_pkg::ST_APPLY: begin
        if (cur.en) begin
          case (cur.op)
            nkro_pkg::OP_KEY_SET: begin
              mod_d = mod_q | cur.mod_mask;
              if (cur.bit_en) bmp_d[BIT_W'(cur.idx)] = 1'b1;
            end
            nkro_pkg::OP_KEY_CLR: begin
              mod_d = mod_q & ~cur.mod_mask;
              if (cur.bit_en) bmp_d[BIT_W'(cur.idx)] = 1'b0;
            end
            nkro_pkg::OP_MEDIA_SET: media_d = media_q | cmd_q.mask;
            nkro_pkg::OP_MEDIA_CLR: media_d = media_q & ~cmd_q.mask;
            nkro_pkg::OP_CLEAR_ALL: begin
              mod_d   = 8'd0;
              bmp_d   = '0;
              media_d = 16'd0;
            end
            nkro_pkg::OP_LINK_UP:   link_d = 1'b1;
            nkro_pkg::OP_LINK_DOWN: link_d = 1'b0;
            default: ;
          endcase
        end
        cnt_d  = '0;
        kind_d = is_media ? nkro_pkg::KIND_MEDIA : nkro_pkg::KIND_KEYBOARD;
        // link state cannot change between the phases, so phase 1 output is known now
        if (!ph_q) begin
          more_d = cmd_q.ph[1].en && cmd_q.ph[1].send && link_q;
          if (!emit_now) ph_d = 1'b1;
        end
      end
      nkro_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_d.report_byte = sel_byte;
          out_d.report_kind = kind_q;
          out_d.status      = !cmd_q.ok;
          out_d.last        = at_end && (ph_q || !more_q);
          out_vld_d         = 1'b1;
          emitted_d         = 1'b1;
          cnt_d             = cnt_q + CNT_W'(1);
          if (at_end && !ph_q) ph_d = 1'b1;
        end
      end
      nkro_pkg::ST_STATUS: begin
        if (slot_free) begin
          out_d.report_byte = 8'd0;
          out_d.report_kind = nkro_pkg::KIND_NONE;
          out_d.status      = !cmd_q.ok;
          out_d.last        = 1'b1;
          out_vld_d         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= nkro_pkg::ST_IDLE;
      ph_q      <= 1'b0;
      cnt_q     <= '0;
      kind_q    <= nkro_pkg::KIND_NONE;
      more_q    <= 1'b0;
      emitted_q <= 1'b0;
      out_vld_q <= 1'b0;
      mod_q     <= 8'd0;
      bmp_q     <= '0;
      media_q   <= 16'd0;
      link_q    <= 1'b0;
    end else begin
      st_q      <= st_d;
      ph_q      <= ph_d;
      cnt_q     <= cnt_d;
      kind_q    <= kind_d;
      more_q    <= more_d;
      emitted_q <= emitted_d;
      out_vld_q <= out_vld_d;
      mod_q     <= mod_d;
      bmp_q     <= bmp_d;
      media_q   <= media_d;
      link_q    <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

endmodule

// ===== sv/nkro_key_report_builder.sv =====
// Channel  Ports                      Request moves when
// -------  -------------------------  -------------------------
// input    push_i, full_o, ev_i       push_i && !full_o
// result   pop_i, empty_o, rpt_o      pop_i && !empty_o
//
// While the link is up, a keyboard event gives KEY_BYTES+2 results, one per cycle unless pop stalls;
// media events give two (four for media type); an event that sends no report gives one
// status result. Typing a key gives up to 2*(KEY_BYTES+2) results; the report
// serializer sets the rate.
// Reset clears the key state and drops the link; no clearing pass is needed.
// Up to two decoded events queue ahead of the serializer; a stalled pop holds it.
module nkro_key_report_builder #(
  parameter int KEY_BYTES = 17
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  nkro_pkg::ev_t  ev_i,
  output logic           empty_o,
  input  logic           pop_i,
  output nkro_pkg::rpt_t rpt_o
);

  nkro_pkg::cmd_t cmd;
  logic           cmd_vld, cmd_rdy, out_vld;

  nkro_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .ev_i      (ev_i),
    .cmd_vld_o (cmd_vld),
    .cmd_rdy_i (cmd_rdy),
    .cmd_o     (cmd)
  );

  nkro_back #(.KEY_BYTES(KEY_BYTES)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_vld_i (cmd_vld),
    .cmd_rdy_o (cmd_rdy),
    .cmd_i     (cmd),
    .out_vld_o (out_vld),
    .pop_i     (pop_i),
    .rpt_o     (rpt_o)
  );

  assign empty_o = !out_vld;

endmodule

// ===== sv/nkro_chk.sv =====
module nkro_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty_o,
  input logic           pop_i,
  input nkro_pkg::rpt_t rpt_o
);

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && rpt_o.report_kind == nkro_pkg::KIND_NONE |-> rpt_o.report_byte == 8'd0)
    else $error("status-only result carries a nonzero byte");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && rpt_o.report_kind == nkro_pkg::KIND_NONE |-> rpt_o.last)
    else $error("status-only result is not last");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> rpt_o.report_kind == nkro_pkg::KIND_NONE ||
                 rpt_o.report_kind == nkro_pkg::KIND_KEYBOARD ||
                 rpt_o.report_kind == nkro_pkg::KIND_MEDIA)
    else $error("invalid report kind");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(rpt_o))
    else $error("waiting result changed before pop");

endmodule

bind nkro_key_report_builder nkro_chk u_chk (.*);
